@@ rtl/fdsa_pkg.sv @@
// Shared types and codes for the fence deferred slot allocator.
package fdsa_pkg;

    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int REL_W    = 9;
    localparam int FENCE_W  = 64;
    localparam int QID_W    = 2;
    localparam int LIMIT_W  = 11;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_FENCE   = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HEAP_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PARKED_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [SLOT_W-1:0]  slot_in;
        logic [QID_W-1:0]   queue_id;
        logic [FENCE_W-1:0] fence_value;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic [STATUS_W-1:0] status;
        logic [REL_W-1:0]    released_count;
    } rsp_t;

    // Parked entry: queue id above slot.
    typedef struct packed {
        logic [FENCE_W-1:0] fence;
        logic [QID_W-1:0]   queue;
        logic [SLOT_W-1:0]  slot;
    } parked_t;

endpackage

@@ rtl/fdsa_free_fifo.sv @@
// Free slot FIFO memory with registered read.
module fdsa_free_fifo
    import fdsa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [SLOT_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [SLOT_W-1:0] rdata
);

    logic [SLOT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fdsa_parked_mem.sv @@
// Parked entry memory: one write port, one registered read port.
module fdsa_parked_mem
    import fdsa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  parked_t       wdata,
    input  logic [AW-1:0] raddr,
    output parked_t       rdata
);

    parked_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fence_deferred_slot_allocator_unit.sv @@
// Top level of the fence deferred slot allocator.
// Usage: pulse start while busy is low; the result word appears on rsp with
// done high for one cycle and cannot be stalled. Allocate, free and fence
// commands are carried out in the execute state, and the reply is registered
// from it. A release walks the parked list: a read state and a compare state
// per entry, plus a swap-with-last write state for each entry released, then
// a reply state. No clearing pass is needed.
module fence_deferred_slot_allocator_unit
    import fdsa_pkg::*;
#(
    parameter int MAX_SLOTS    = 1024,
    parameter int PARKED_DEPTH = 256,
    parameter int NUM_QUEUES   = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    output logic               done,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int FAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FCW = $clog2(MAX_SLOTS + 1);
    localparam int PAW = (PARKED_DEPTH > 1) ? $clog2(PARKED_DEPTH) : 1;
    localparam int PCW = $clog2(PARKED_DEPTH + 1);
    localparam logic [FCW-1:0] MAX_SLOTS_C = FCW'(MAX_SLOTS);
    localparam logic [PCW-1:0] PDEPTH_C    = PCW'(PARKED_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RREAD = 5'b00100,
        S_RCHK  = 5'b01000,
        S_RLAST = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [FAW-1:0]     head_reg, tail_reg;
    logic [FCW-1:0]     fcount_reg;
    logic [FCW-1:0]     water_reg;
    logic [PCW-1:0]     pcount_reg;
    logic [PCW-1:0]     idx_reg;
    logic [REL_W-1:0]   rel_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [FENCE_W-1:0] comp_reg [NUM_QUEUES];
    parked_t            cur_reg;
    logic               done_reg;
    rsp_t               rsp_reg;

    logic           f_we;
    logic [FAW-1:0] f_raddr;
    logic [SLOT_W-1:0] f_rdata;
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    parked_t        p_wdata, p_rdata;

    fdsa_free_fifo #(.DEPTH(MAX_SLOTS), .AW(FAW)) u_fifo (
        .clk   (clk),
        .we    (f_we),
        .waddr (tail_reg),
        .wdata (cur_reg.slot),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    fdsa_parked_mem #(.DEPTH(PARKED_DEPTH), .AW(PAW)) u_park (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    logic [FCW-1:0] lim_eff;
    logic [FENCE_W-1:0] comp_cur;
    logic [PCW-1:0] last_idx;

    assign lim_eff  = ({{(FCW > LIMIT_W ? FCW-LIMIT_W : 1){1'b0}}, limit_reg} >
                       {{(FCW > LIMIT_W ? 1 : LIMIT_W-FCW+1){1'b0}}, MAX_SLOTS_C})
                      ? MAX_SLOTS_C : FCW'(limit_reg);
    assign last_idx = pcount_reg - PCW'(1);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign f_raddr   = head_reg;

    always_comb
    begin
        comp_cur = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (32'(p_rdata.queue) == q)
            begin
                comp_cur = comp_reg[q];
            end
        end
    end

    // Read address: last entry while checking, else walk index.
    always_comb
    begin
        p_raddr = (state_reg == S_RCHK) ? PAW'(last_idx) : PAW'(idx_reg);
        p_we    = 1'b0;
        p_waddr = PAW'(idx_reg);
        p_wdata = p_rdata;
        f_we    = 1'b0;
        if (state_reg == S_EXEC && cmd_reg.func == FUNC_FREE && pcount_reg < PDEPTH_C)
        begin
            p_we    = 1'b1;
            p_waddr = PAW'(pcount_reg);
            p_wdata.fence = cmd_reg.fence_value;
            p_wdata.queue = cmd_reg.queue_id;
            p_wdata.slot  = cmd_reg.slot_in;
        end
        else if (state_reg == S_RLAST)
        begin
            p_we  = 1'b1;
            f_we  = (fcount_reg < MAX_SLOTS_C);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = (cmd.func == FUNC_RELEASE) ? S_RREAD : S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            S_RREAD: state_next = (idx_reg < pcount_reg) ? S_RCHK : S_IDLE;
            S_RCHK:  state_next = (comp_cur >= p_rdata.fence) ? S_RLAST : S_RREAD;
            S_RLAST: state_next = S_RREAD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fcount_reg <= '0;
            water_reg  <= '0;
            pcount_reg <= '0;
            idx_reg    <= '0;
            rel_reg    <= '0;
            limit_reg  <= LIMIT_W'(1024);
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                comp_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC) ||
                         (state_reg == S_RREAD && idx_reg >= pcount_reg);
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    rel_reg <= '0;
                end
                S_EXEC:
                begin
                    unique case (func_t'(cmd_reg.func))
                        FUNC_ALLOC:
                        begin
                            if (fcount_reg != '0)
                            begin
                                rsp_reg    <= '{slot_out: f_rdata, status: ST_OK,
                                                released_count: '0};
                                head_reg   <= (32'(head_reg) == MAX_SLOTS-1) ? '0
                                              : head_reg + FAW'(1);
                                fcount_reg <= fcount_reg - FCW'(1);
                            end
                            else if (water_reg < lim_eff)
                            begin
                                rsp_reg   <= '{slot_out: SLOT_W'(water_reg), status: ST_OK,
                                               released_count: '0};
                                water_reg <= water_reg + FCW'(1);
                            end
                            else
                            begin
                                rsp_reg <= '{slot_out: '0, status: ST_HEAP_FULL,
                                             released_count: '0};
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (pcount_reg < PDEPTH_C)
                            begin
                                pcount_reg <= pcount_reg + PCW'(1);
                                rsp_reg    <= '0;
                            end
                            else
                            begin
                                rsp_reg <= '{slot_out: '0, status: ST_PARKED_FULL,
                                             released_count: '0};
                            end
                        end
                        FUNC_FENCE:
                        begin
                            rsp_reg <= '0;
                            for (int q = 0; q < NUM_QUEUES; q++)
                            begin
                                if (32'(cmd_reg.queue_id) == q)
                                begin
                                    comp_reg[q] <= cmd_reg.fence_value;
                                end
                            end
                        end
                        default: rsp_reg <= '0;
                    endcase
                end
                S_RREAD:
                begin
                    if (idx_reg >= pcount_reg)
                    begin
                        rsp_reg <= '{slot_out: '0, status: ST_OK, released_count: rel_reg};
                    end
                end
                S_RCHK:
                begin
                    if (comp_cur < p_rdata.fence)
                    begin
                        idx_reg <= idx_reg + PCW'(1);
                    end
                end
                S_RLAST:
                begin
                    // Move last into the hole, push the due slot.
                    if (fcount_reg < MAX_SLOTS_C)
                    begin
                        tail_reg   <= (32'(tail_reg) == MAX_SLOTS-1) ? '0
                                      : tail_reg + FAW'(1);
                        fcount_reg <= fcount_reg + FCW'(1);
                    end
                    pcount_reg <= last_idx;
                    rel_reg    <= rel_reg + REL_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Hold the command and the checked entry.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_RCHK)
        begin
            cur_reg <= p_rdata;
        end
    end

endmodule
